[src/unordered_list_table_defines.svh]
// Assertion macros shared by the list table RTL.
`ifndef UNORDERED_LIST_TABLE_DEFINES_SVH
`define UNORDERED_LIST_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ULT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ULT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ult_pkg.sv]
// Types and constants of the unordered list table.
`timescale 1ns / 1ps

package ult_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int MODE_W  = 3;
  localparam int POS_W   = 6;
  localparam int WORD_W  = 32;
  localparam int STAT_W  = 3;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;

  typedef enum logic [MODE_W-1:0] {
    M_APPEND    = 3'd0,
    M_INSERT    = 3'd1,
    M_SEARCH    = 3'd2,
    M_DEL_AT    = 3'd3,
    M_DEL_VAL   = 3'd4,
    M_DEL_LAST  = 3'd5,
    M_CLEAR     = 3'd6
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

endpackage

[src/ult_in_if.sv]
// Operation channel: valid/ready with mode, position and value.
`timescale 1ns / 1ps

interface ult_in_if;
  import ult_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [POS_W-1:0]         position;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output mode, output position, output value, input ready);
  modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

[src/ult_out_if.sv]
// Result channel: valid/ready with status, index, popped word and count.
`timescale 1ns / 1ps

interface ult_out_if;
  import ult_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic [INDEX_W-1:0]       index;
  logic signed [WORD_W-1:0] word_out;
  logic [COUNT_W-1:0]       count_out;

  modport source (output valid, output status, output index, output word_out,
                  output count_out, input ready);
  modport sink   (input valid, input status, input index, input word_out,
                  input count_out, output ready);
endinterface

[src/ult_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ult_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/unordered_list_table.sv]
// Unordered list table: bounded word list with swap delete, one RAM and a sequencer.
//
//   channel  | dir | payload                              | handshake
//   in_ch    | in  | mode, position, value                | valid/ready, ready only when idle
//   out_ch   | out | status, index, word_out, count_out   | valid/ready, one-deep output reg
//
// Sequence per item: append, clear, an unused mode, a bad position or a full list go
// from decode straight to done; delete_at passes fill, delete_last passes pop, insert_at
// passes its read and write states; search scans up to count entries, delete_value then fills.
// The scan reads one entry per cycle through the single RAM read port.
// Reset clears the count and the sequencer; entries are not cleared.
// A stalled result sits in the output register while the next item is accepted.
`timescale 1ns / 1ps
`include "unordered_list_table_defines.svh"

module unordered_list_table (
  input  logic clk,
  input  logic rst_n,
  ult_in_if.sink    in_ch,
  ult_out_if.source out_ch
);
  import ult_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_INS_RD,
    S_INS_WR,
    S_FILL,
    S_POP,
    S_DONE
  } state_t;

  state_t                   state_r, state_nxt;
  mode_t                    mode_r, mode_nxt;
  logic [POS_W-1:0]         pos_r, pos_nxt;
  logic signed [WORD_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         scan_idx_r, scan_idx_nxt;
  logic                     rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]         rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]         tgt_r, tgt_nxt;
  status_t                  res_status_r, res_status_nxt;
  logic [INDEX_W-1:0]       res_idx_r, res_idx_nxt;
  logic signed [WORD_W-1:0] res_word_r, res_word_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]        out_status_r, out_status_nxt;
  logic [INDEX_W-1:0]       out_idx_r, out_idx_nxt;
  logic signed [WORD_W-1:0] out_word_r, out_word_nxt;
  logic [COUNT_W-1:0]       out_count_r, out_count_nxt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic             pos_bad;
  logic             is_full;
  logic [CNT_W-1:0] count_dec;
  logic [IDX_W-1:0] tail_addr;
  logic             hit;

  ult_ram #(
    .WIDTH(WORD_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pos_bad   = (32'(pos_r) >= 32'(count_r));
  assign is_full   = (count_r == CNT_W'(CAPACITY));
  assign count_dec = count_r - CNT_W'(1);
  assign tail_addr = count_dec[IDX_W-1:0];
  assign hit       = rd_pend_r && (ram_rdata == val_r);

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.index     = out_idx_r;
  assign out_ch.word_out  = out_word_r;
  assign out_ch.count_out = out_count_r;

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    count_nxt      = count_r;
    scan_idx_nxt   = scan_idx_r;
    rd_pend_nxt    = rd_pend_r;
    rd_idx_nxt     = rd_idx_r;
    tgt_nxt        = tgt_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_word_nxt   = res_word_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_word_nxt   = out_word_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_waddr      = count_r[IDX_W-1:0];
    ram_wdata      = val_r;
    ram_raddr      = tail_addr;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt       = mode_t'(in_ch.mode);
          pos_nxt        = in_ch.position;
          val_nxt        = in_ch.value;
          res_status_nxt = ST_OK;
          res_idx_nxt    = '0;
          res_word_nxt   = '0;
          state_nxt      = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        case (mode_r)
          M_APPEND: begin
            if (is_full) begin
              res_status_nxt = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end
          end
          M_INSERT: begin
            if (pos_bad) begin
              res_status_nxt = ST_BADPOS;
            end else if (is_full) begin
              res_status_nxt = ST_FULL;
            end else begin
              ram_raddr = IDX_W'(pos_r);
              state_nxt = S_INS_RD;
            end
          end
          M_SEARCH, M_DEL_VAL: begin
            scan_idx_nxt = '0;
            rd_pend_nxt  = 1'b0;
            state_nxt    = S_SCAN;
          end
          M_DEL_AT: begin
            if (pos_bad) begin
              res_status_nxt = ST_BADPOS;
            end else begin
              tgt_nxt   = IDX_W'(pos_r);
              state_nxt = S_FILL;
            end
          end
          M_DEL_LAST: begin
            if (count_r == '0) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              state_nxt = S_POP;
            end
          end
          M_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        if (hit) begin
          rd_pend_nxt = 1'b0;
          if (mode_r == M_SEARCH) begin
            res_idx_nxt = INDEX_W'(rd_idx_r);
            state_nxt   = S_DONE;
          end else begin
            tgt_nxt   = rd_idx_r;
            state_nxt = S_FILL;
          end
        end else if (scan_idx_r < count_r) begin
          ram_raddr    = scan_idx_r[IDX_W-1:0];
          rd_pend_nxt  = 1'b1;
          rd_idx_nxt   = scan_idx_r[IDX_W-1:0];
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
        end else begin
          rd_pend_nxt    = 1'b0;
          res_status_nxt = ST_NOTFOUND;
          state_nxt      = S_DONE;
        end
      end
      S_INS_RD: begin
        ram_we    = 1'b1;
        ram_waddr = count_r[IDX_W-1:0];
        ram_wdata = ram_rdata;
        state_nxt = S_INS_WR;
      end
      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(pos_r);
        ram_wdata = val_r;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_DONE;
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = tgt_r;
        ram_wdata = ram_rdata;
        count_nxt = count_dec;
        state_nxt = S_DONE;
      end
      S_POP: begin
        res_word_nxt = $signed(ram_rdata);
        count_nxt    = count_dec;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_idx_nxt    = res_idx_r;
          out_word_nxt   = res_word_r;
          out_count_nxt  = COUNT_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r       <= mode_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    scan_idx_r   <= scan_idx_nxt;
    rd_idx_r     <= rd_idx_nxt;
    tgt_r        <= tgt_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_word_r   <= res_word_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_word_r   <= out_word_nxt;
    out_count_r  <= out_count_nxt;
  end

  `ULT_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY), "count above capacity")
  `ULT_ASSERT_NEXT(a_accept_decode, in_ch.valid && in_ch.ready, state_r == S_DECODE, "transfer not decoded")
  `ULT_ASSERT_NEXT(a_done_loads, (state_r == S_DONE) && (!out_valid_r || out_ch.ready), out_valid_r && (state_r == S_IDLE), "result not loaded")
  `ULT_ASSERT_IMPL(a_scan_range, state_r == S_SCAN, scan_idx_r <= count_r, "scan past count")

endmodule

[tb/tb.sv]
// Self-checking testbench for the unordered list table: random list traffic against a predictor.
`timescale 1ns / 1ps

module tb;
  import ult_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam int OPS_PER_PHASE = 600;
  localparam int SETTLE_CYCLES = 100;

  typedef struct {
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] value;
  } list_op_t;

  typedef struct {
    status_t                  status;
    logic [INDEX_W-1:0]       index;
    logic signed [WORD_W-1:0] word;
    logic [COUNT_W-1:0]       count;
  } list_result_t;

  typedef enum {GROW, SHRINK, MIXED, PROBE} traffic_t;

  logic clk;
  logic rst_n;

  ult_in_if  in_ch ();
  ult_out_if out_ch ();

  unordered_list_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  list_op_t     pending_ops[$];
  list_result_t results_due[$];

  logic signed [WORD_W-1:0] shadow_words[CAPACITY];
  int                       shadow_count;

  logic signed [WORD_W-1:0] value_pool[8] = '{
    32'sd0, -32'sd1, 32'sd1, 32'sh8000_0000, 32'sh7FFF_FFFF,
    32'sh5555_5555, 32'shAAAA_AAAA, 32'sd42
  };

  traffic_t traffic;
  int       traffic_left;
  int       send_idle_pct;
  int       recv_idle_pct;
  int       errors;
  int       ops_sent;
  int       results_checked;
  int       mode_seen[8];
  int       status_seen[8];

  always #2 clk = ~clk;

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = M_APPEND;
    in_ch.position  = '0;
    in_ch.value     = '0;
    out_ch.ready    = 1'b0;
    shadow_count    = 0;
    traffic         = GROW;
    traffic_left    = 0;
    send_idle_pct   = 7;
    recv_idle_pct   = 46;
    errors          = 0;
    ops_sent        = 0;
    results_checked = 0;
    foreach (mode_seen[i]) mode_seen[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Predictor: applies one operation to the shadow list and returns its result.
  function automatic list_result_t apply_list_op(list_op_t op);
    list_result_t r;
    int hit;
    int drop;
    r.status = ST_OK;
    r.index  = '0;
    r.word   = '0;
    hit      = -1;
    drop     = -1;
    for (int i = shadow_count - 1; i >= 0; i--) begin
      if (shadow_words[i] == op.value) hit = i;
    end
    case (op.mode)
      M_APPEND: begin
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_words[shadow_count] = op.value;
          shadow_count++;
        end
      end
      M_INSERT: begin
        if (op.position >= shadow_count) begin
          r.status = ST_BADPOS;
        end else if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_words[shadow_count] = shadow_words[op.position];
          shadow_words[op.position]  = op.value;
          shadow_count++;
        end
      end
      M_SEARCH: begin
        if (hit < 0) r.status = ST_NOTFOUND;
        else r.index = INDEX_W'(hit);
      end
      M_DEL_AT: begin
        if (op.position >= shadow_count) r.status = ST_BADPOS;
        else drop = op.position;
      end
      M_DEL_VAL: begin
        if (hit < 0) r.status = ST_NOTFOUND;
        else drop = hit;
      end
      M_DEL_LAST: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.word = shadow_words[shadow_count - 1];
          shadow_count--;
        end
      end
      M_CLEAR: shadow_count = 0;
      default: ;
    endcase
    if (drop >= 0) begin
      shadow_words[drop] = shadow_words[shadow_count - 1];
      shadow_count--;
    end
    r.count = COUNT_W'(shadow_count);
    return r;
  endfunction

  task automatic push_op(logic [MODE_W-1:0] mode, int position, logic signed [WORD_W-1:0] value);
    list_op_t op;
    op.mode     = mode;
    op.position = POS_W'(position);
    op.value    = value;
    pending_ops.push_back(op);
  endtask

  // Fill, drain, probe and mixed runs with random content, tracking an estimate of the count.
  task automatic queue_random_ops(int n);
    list_op_t op;
    int est;
    int r;
    int rv;
    est = shadow_count;
    repeat (n) begin
      r = $urandom_range(99);
      case (traffic)
        GROW:    op.mode = r < 55 ? M_APPEND : r < 90 ? M_INSERT : r < 95 ? M_SEARCH : M_DEL_AT;
        SHRINK:  op.mode = r < 35 ? M_DEL_AT : r < 60 ? M_DEL_VAL : r < 95 ? M_DEL_LAST : M_SEARCH;
        PROBE:   op.mode = r < 60 ? M_SEARCH : r < 80 ? M_DEL_VAL : M_APPEND;
        default: begin
          if (r < 3) op.mode = M_CLEAR;
          else if (r < 6) op.mode = MODE_UNUSED;
          else op.mode = MODE_W'($urandom_range(5));
        end
      endcase
      if (est > 0 && $urandom_range(9) != 0) op.position = POS_W'($urandom_range(est - 1));
      else op.position = POS_W'($urandom_range(63));
      rv = $urandom_range(99);
      if (rv < 35 && shadow_count > 0) op.value = shadow_words[$urandom_range(shadow_count - 1)];
      else if (rv < 65) op.value = value_pool[$urandom_range(7)];
      else op.value = $urandom();
      case (op.mode)
        M_APPEND:   if (est < CAPACITY) est++;
        M_INSERT:   if (op.position < est && est < CAPACITY) est++;
        M_DEL_AT:   if (op.position < est) est--;
        M_DEL_VAL:  if (est > 0 && rv < 35) est--;
        M_DEL_LAST: if (est > 0) est--;
        M_CLEAR:    est = 0;
        default: ;
      endcase
      traffic_left--;
      if (traffic == GROW && est < CAPACITY) traffic_left = 4;
      if (traffic == SHRINK && est > 0) traffic_left = 3;
      if (traffic_left <= 0) begin
        traffic      = traffic_t'($urandom_range(3));
        traffic_left = $urandom_range(10, 60);
      end
      pending_ops.push_back(op);
    end
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || in_ch.valid || results_due.size() != 0) @(negedge clk);
  endtask

  // Operation driver: predicts each transfer as it is accepted.
  always @(posedge clk) begin : drive_ops
    list_op_t op;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        op.mode     = in_ch.mode;
        op.position = in_ch.position;
        op.value    = in_ch.value;
        results_due.push_back(apply_list_op(op));
        mode_seen[op.mode]++;
        ops_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          op = pending_ops.pop_front();
          in_ch.mode     <= op.mode;
          in_ch.position <= op.position;
          in_ch.value    <= op.value;
          in_ch.valid    <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: status %0d index %0d word %0d count %0d",
                     out_ch.status, out_ch.index, out_ch.word_out, out_ch.count_out);
        end else begin
          want = results_due.pop_front();
          results_checked++;
          status_seen[want.status]++;
          if (out_ch.status !== want.status || out_ch.index !== want.index ||
              out_ch.word_out !== want.word || out_ch.count_out !== want.count) begin
            errors++;
            if (errors <= 10)
              $display("mismatch on result %0d: status %0d/%0d index %0d/%0d word %0d/%0d count %0d/%0d (exp/got)",
                       results_checked, want.status, out_ch.status, want.index, out_ch.index,
                       want.word, out_ch.word_out, want.count, out_ch.count_out);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : stimulus
    int send_idle[3] = '{7, 46, 0};
    int recv_idle[3] = '{46, 7, 0};
    int queued;
    while (!rst_n) @(negedge clk);

    // Empty-list corner cases.
    push_op(M_DEL_LAST, 0, 32'sd0);
    push_op(M_INSERT, 0, 32'sd9);
    push_op(M_DEL_AT, 63, 32'sd0);
    push_op(M_SEARCH, 0, 32'sd0);
    push_op(M_DEL_VAL, 0, -32'sd1);
    // Extreme words, duplicate search picks the lowest index.
    push_op(M_APPEND, 63, 32'sh8000_0000);
    push_op(M_APPEND, 0, 32'sh7FFF_FFFF);
    push_op(M_APPEND, 0, -32'sd1);
    push_op(M_APPEND, 0, 32'sd0);
    push_op(M_APPEND, 0, 32'sh7FFF_FFFF);
    push_op(M_SEARCH, 0, 32'sh7FFF_FFFF);
    push_op(M_SEARCH, 0, 32'sd12345);
    push_op(M_INSERT, 0, 32'sd5);
    push_op(M_DEL_AT, 1, 32'sd0);
    push_op(M_DEL_VAL, 63, -32'sd1);
    push_op(M_DEL_LAST, 0, 32'sd0);
    push_op(MODE_UNUSED, 63, -32'sd1);
    push_op(M_INSERT, 3, 32'sd7);
    push_op(M_DEL_AT, 3, 32'sd0);
    push_op(M_CLEAR, 63, -32'sd1);
    push_op(M_DEL_LAST, 0, 32'sd0);
    wait_drained();

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = send_idle[p];
      recv_idle_pct = recv_idle[p];
      queued = 0;
      while (queued < OPS_PER_PHASE) begin
        queue_random_ops(16);
        queued += 16;
        while (pending_ops.size() != 0 || in_ch.valid) @(negedge clk);
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("sent %0d operations (append %0d, insert %0d, search %0d, delete %0d/%0d/%0d, clear %0d)",
             ops_sent, mode_seen[M_APPEND], mode_seen[M_INSERT], mode_seen[M_SEARCH],
             mode_seen[M_DEL_AT], mode_seen[M_DEL_VAL], mode_seen[M_DEL_LAST], mode_seen[M_CLEAR]);
    $display("checked %0d results: ok %0d, bad position %0d, miss %0d, full %0d, empty %0d",
             results_checked, status_seen[ST_OK], status_seen[ST_BADPOS],
             status_seen[ST_NOTFOUND], status_seen[ST_FULL], status_seen[ST_EMPTY]);
    if (errors == 0 && results_due.size() == 0) begin
      $display("[unordered_list_table] OK");
    end else begin
      $display("%0d errors, %0d results outstanding", errors, results_due.size());
      $display("[unordered_list_table] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("timeout with %0d results outstanding", results_due.size());
    $display("[unordered_list_table] ERROR");
    $finish;
  end

endmodule
